// ----- hw/rtl/wfdd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wfdd_pkg
// shared codes for the wait-for deadlock detector
// ----------------------------------------------------------------------------
package wfdd_pkg;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_PROC   = 3'd1;
   localparam logic [2:0] OP_LOCK   = 3'd2;
   localparam logic [2:0] OP_WAIT   = 3'd3;
   localparam logic [2:0] OP_DETECT = 3'd4;

   localparam logic [4:0] GROUP_CAP = 5'd31;
   localparam logic [7:0] RES_CAP   = 8'd32;

   typedef struct packed {
      logic [4:0]  deadlock_index;
      logic [15:0] member_name;
      logic [4:0]  deadlock_total;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/wait_for_deadlock_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wait_for_deadlock_detector
// loads process, lock and wait tables and finds wait-for cycles on detect
// ----------------------------------------------------------------------------
// Load transfers (clear, add process, add lock, add request) are accepted in
// idle and update the tables directly. A detect transfer walks the waits-for
// chains: every chain step reads the waited-key memory, then the key-owner
// memory, each slot is scanned in turn, every member of a found group gets its
// group number written, and then the result phase visits each group and slot
// pair, waiting whenever the result side stalls. The block takes no new
// transfer until the last result of a detect is loaded into the output
// register. A clear resets the table valid bits; there is no clearing pass.
module wait_for_deadlock_detector #(
   parameter int MAX_PROCS = 32,
   parameter int MAX_KEYS  = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // opcode, proc_slot, proc_name, key_id, zero pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // deadlock_index, member_name, deadlock_total, zero pad
   output logic        rsp_tlast
);
   import wfdd_pkg::*;

   localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int PCW = $clog2(MAX_PROCS + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_W1    = 4'd2;
   localparam logic [3:0] ST_W2    = 4'd3;
   localparam logic [3:0] ST_W3    = 4'd4;
   localparam logic [3:0] ST_G1    = 4'd5;
   localparam logic [3:0] ST_G2    = 4'd6;
   localparam logic [3:0] ST_OINIT = 4'd7;
   localparam logic [3:0] ST_ORD   = 4'd8;
   localparam logic [3:0] ST_OCHK  = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [MAX_PROCS-1:0] present_ff, present_in, holds_ff, holds_in;
   logic [MAX_PROCS-1:0] wkv_ff, wkv_in, open_ff, open_in;
   logic [MAX_PROCS-1:0] onpath_ff, onpath_in, ingrp_ff, ingrp_in;
   logic [MAX_KEYS-1:0]  keyv_ff, keyv_in;
   logic [PCW-1:0]       s_ff, s_in, len_ff, len_in, idx_ff, idx_in;
   logic [PCW-1:0]       members_ff, members_in;
   logic [PW-1:0]        cur_ff, cur_in, p_ff, p_in;
   logic [4:0]           groups_ff, groups_in;
   logic [5:0]           g_ff, g_in, n_ff, n_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [15:0] name_mem [MAX_PROCS];
   logic [PW-1:0] owner_mem [MAX_KEYS];
   logic [KW-1:0] wait_mem [MAX_PROCS];
   logic [4:0]  grp_mem [MAX_PROCS];
   logic [PW-1:0] stack_mem [MAX_PROCS];
   logic [15:0] name_rd;
   logic [PW-1:0] owner_rd, stack_rd;
   logic [KW-1:0] wait_rd;
   logic [4:0]  grp_rd;

   logic          name_we, owner_we, wait_we, grp_we, stack_we;
   logic [PW-1:0] name_wa, wait_wa, grp_wa, stack_wa, owner_wd, stack_wd;
   logic [KW-1:0] owner_wa, wait_wd;
   logic [15:0]   name_wd;
   logic [4:0]    grp_wd;

   logic [2:0]  op;
   logic [8:0]  slot_x, key_x;
   logic        slot_ok, key_ok, req_xfer, out_free, hit;
   logic [PW-1:0] slot_i, s_i;
   logic [KW-1:0] key_i;
   logic [7:0]  cap, n_next;

   assign op      = req_tdata[2:0];
   assign slot_x  = {4'b0, req_tdata[7:3]};
   assign key_x   = {3'b0, req_tdata[29:24]};
   assign slot_ok = slot_x < 9'(MAX_PROCS);
   assign key_ok  = key_x < 9'(MAX_KEYS);
   assign slot_i  = slot_x[PW-1:0];
   assign key_i   = key_x[KW-1:0];
   assign s_i     = s_ff[PW-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cap        = (8'(members_ff) > RES_CAP) ? RES_CAP : 8'(members_ff);
   assign n_next     = 8'(n_ff) + 8'd1;
   assign hit        = ingrp_ff[p_ff] && (6'(grp_rd) == g_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {6'b0, rsp_ff.deadlock_total, rsp_ff.member_name,
                        rsp_ff.deadlock_index};

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      holds_in     = holds_ff;
      wkv_in       = wkv_ff;
      open_in      = open_ff;
      onpath_in    = onpath_ff;
      ingrp_in     = ingrp_ff;
      keyv_in      = keyv_ff;
      s_in         = s_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      members_in   = members_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      groups_in    = groups_ff;
      g_in         = g_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      name_we = 1'b0; name_wa = slot_i; name_wd = req_tdata[23:8];
      owner_we = 1'b0; owner_wa = key_i; owner_wd = slot_i;
      wait_we = 1'b0; wait_wa = slot_i; wait_wd = key_i;
      grp_we = 1'b0; grp_wa = stack_rd; grp_wd = groups_ff;
      stack_we = 1'b0; stack_wa = '0; stack_wd = s_i;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (op)
                  OP_CLEAR: begin
                     present_in = '0;
                     holds_in   = '0;
                     wkv_in     = '0;
                     keyv_in    = '0;
                  end
                  OP_PROC: begin
                     if (slot_ok) begin
                        present_in[slot_i] = 1'b1;
                        name_we = 1'b1;
                     end
                  end
                  OP_LOCK: begin
                     if (slot_ok && key_ok && !keyv_ff[key_i]) begin
                        keyv_in[key_i]   = 1'b1;
                        holds_in[slot_i] = 1'b1;
                        owner_we = 1'b1;
                     end
                  end
                  OP_WAIT: begin
                     if (slot_ok && key_ok && !wkv_ff[slot_i]) begin
                        wkv_in[slot_i] = 1'b1;
                        wait_we = 1'b1;
                     end
                  end
                  OP_DETECT: begin
                     open_in    = present_ff & holds_ff;
                     ingrp_in   = '0;
                     groups_in  = '0;
                     members_in = '0;
                     s_in       = '0;
                     state_in   = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (s_ff == PCW'(MAX_PROCS)) begin
               state_in = ST_OINIT;
            end else if (!open_ff[s_i]) begin
               s_in = s_ff + 1'b1;
            end else begin
               cur_in          = s_i;
               len_in          = PCW'(1);
               onpath_in       = '0;
               onpath_in[s_i]  = 1'b1;
               stack_we        = 1'b1;
               state_in        = ST_W1;
            end
         end
         ST_W1: state_in = ST_W2;
         ST_W2: begin
            if (!wkv_ff[cur_ff]) begin
               open_in  = open_ff & ~onpath_ff;
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_W3;
            end
         end
         ST_W3: begin
            if (!keyv_ff[wait_rd] || !present_ff[owner_rd]) begin
               open_in  = open_ff & ~onpath_ff;
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end else if (owner_rd == s_i) begin
               open_in = open_ff & ~onpath_ff;
               if (groups_ff < GROUP_CAP) begin
                  groups_in  = groups_ff + 1'b1;
                  ingrp_in   = ingrp_ff | onpath_ff;
                  members_in = members_ff + len_ff;
                  idx_in     = '0;
                  state_in   = ST_G1;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (!open_ff[owner_rd]) begin
               open_in  = open_ff & ~onpath_ff;
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end else if (onpath_ff[owner_rd] || len_ff == PCW'(MAX_PROCS)) begin
               open_in[s_i] = 1'b0;
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               stack_we  = 1'b1;
               stack_wa  = len_ff[PW-1:0];
               stack_wd  = owner_rd;
               onpath_in[owner_rd] = 1'b1;
               len_in    = len_ff + 1'b1;
               cur_in    = owner_rd;
               state_in  = ST_W1;
            end
         end
         ST_G1: state_in = ST_G2;
         ST_G2: begin
            grp_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == len_ff) begin
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_G1;
            end
         end
         ST_OINIT: begin
            if (groups_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{deadlock_index: 5'd0, member_name: 16'd0,
                                   deadlock_total: 5'd0, last: 1'b1};
                  state_in     = ST_IDLE;
               end
            end else begin
               g_in     = 6'd1;
               p_in     = '0;
               n_in     = '0;
               state_in = ST_ORD;
            end
         end
         ST_ORD: state_in = ST_OCHK;
         ST_OCHK: begin
            if (hit && !out_free) begin
               state_in = ST_OCHK;
            end else begin
               if (hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{deadlock_index: g_ff[4:0], member_name: name_rd,
                                   deadlock_total: groups_ff, last: n_next == cap};
                  n_in         = n_next[5:0];
               end
               if (hit && n_next == cap) begin
                  state_in = ST_IDLE;
               end else if (p_ff == PW'(MAX_PROCS - 1)) begin
                  p_in = '0;
                  g_in = g_ff + 1'b1;
                  state_in = (g_ff == 6'(groups_ff)) ? ST_IDLE : ST_ORD;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         holds_ff     <= '0;
         wkv_ff       <= '0;
         keyv_ff      <= '0;
         open_ff      <= '0;
         onpath_ff    <= '0;
         ingrp_ff     <= '0;
         s_ff         <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         members_ff   <= '0;
         cur_ff       <= '0;
         p_ff         <= '0;
         groups_ff    <= '0;
         g_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         holds_ff     <= holds_in;
         wkv_ff       <= wkv_in;
         keyv_ff      <= keyv_in;
         open_ff      <= open_in;
         onpath_ff    <= onpath_in;
         ingrp_ff     <= ingrp_in;
         s_ff         <= s_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         members_ff   <= members_in;
         cur_ff       <= cur_in;
         p_ff         <= p_in;
         groups_ff    <= groups_in;
         g_ff         <= g_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // table memories
   always_ff @(posedge clock) begin
      if (name_we) name_mem[name_wa] <= name_wd;
      name_rd <= name_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (owner_we) owner_mem[owner_wa] <= owner_wd;
      owner_rd <= owner_mem[wait_rd];
   end

   always_ff @(posedge clock) begin
      if (wait_we) wait_mem[wait_wa] <= wait_wd;
      wait_rd <= wait_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (grp_we) grp_mem[grp_wa] <= grp_wd;
      grp_rd <= grp_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wa] <= stack_wd;
      stack_rd <= stack_mem[idx_ff[PW-1:0]];
   end

`ifndef SYNTH
   a_group_cap: assert property (@(posedge clock) disable iff (reset)
      groups_ff <= GROUP_CAP)
      else $error("group count beyond cap");

   a_path_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W1 || state_ff == ST_W2 || state_ff == ST_W3)
      |-> ((onpath_ff & ~open_ff) == '0))
      else $error("path holds a closed slot");

   a_path_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W1 || state_ff == ST_W2 || state_ff == ST_W3)
      |-> ($countones(onpath_ff) == int'(len_ff)))
      else $error("path length mismatch");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_OCHK) |-> rsp_valid_ff || $past(rsp_tready))
      else $error("detect ended with no result loaded");
`endif

endmodule
`default_nettype wire

// ----- tb/wfdd_checker.sv -----
// ----------------------------------------------------------------------------
// wfdd_checker
// Watches the request and response streams of the wait-for deadlock detector.
// It keeps its own copy of the process, lock and wait tables. On each detect
// transfer it queues the expected responses: the group members, or one empty
// result. Each response is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module wfdd_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [31:0] req_tdata,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [31:0] rsp_tdata,
   input  wire        rsp_tlast,
   output int         errors,
   output int         pending
);
   import wfdd_pkg::*;

   localparam int NPROC = 32;
   localparam int NKEY  = 64;
   localparam int OPEN  = 63;

   bit          present [NPROC];
   logic [15:0] pname   [NPROC];
   int          owner   [NKEY];
   int          waiting [NPROC];
   int          mark    [NPROC];
   int          path    [NPROC];
   rsp_type     members_due [$];

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic void wipe_tables();
      for (int i = 0; i < NPROC; i++) begin
         present[i] = 0;
         waiting[i] = -1;
         mark[i] = OPEN;
      end
      for (int i = 0; i < NKEY; i++) owner[i] = -1;
   endfunction

   function automatic int next_hop(int p);
      int o;
      if (waiting[p] < 0) return -1;
      o = owner[waiting[p]];
      if (o < 0 || !present[o]) return -1;
      return o;
   endfunction

   function automatic void mark_chain(int len, int m);
      for (int i = 0; i < len; i++) mark[path[i]] = m;
   endfunction

   function automatic int find_groups();
      int groups;
      int len;
      int cur;
      int nx;
      bit holds;
      bit seen;
      groups = 0;
      for (int p = 0; p < NPROC; p++) begin
         holds = 0;
         for (int k = 0; k < NKEY; k++) if (owner[k] == p) holds = 1;
         mark[p] = (present[p] && holds) ? OPEN : 0;
      end
      for (int s = 0; s < NPROC; s++) begin
         if (mark[s] == OPEN) begin
            path[0] = s;
            len = 1;
            cur = s;
            forever begin
               nx = next_hop(cur);
               if (nx < 0) begin
                  mark_chain(len, 0);
                  break;
               end
               if (nx == s) begin
                  if (groups < GROUP_CAP) begin
                     groups++;
                     mark_chain(len, groups);
                  end else begin
                     mark_chain(len, 0);
                  end
                  break;
               end
               if (mark[nx] != OPEN) begin
                  mark_chain(len, 0);
                  break;
               end
               seen = 0;
               for (int i = 1; i < len; i++) if (path[i] == nx) seen = 1;
               if (seen || len >= NPROC) begin
                  mark[s] = 0;
                  break;
               end
               path[len] = nx;
               len++;
               cur = nx;
            end
         end
      end
      return groups;
   endfunction

   function automatic void apply_transfer(logic [31:0] d);
      logic [2:0] op;
      int slot;
      int key;
      int groups;
      int n;
      rsp_type r;
      op = d[2:0];
      slot = d[7:3];
      key = d[29:24];
      case (op)
         OP_CLEAR: wipe_tables();
         OP_PROC: begin
            present[slot] = 1;
            pname[slot] = d[23:8];
         end
         OP_LOCK: if (owner[key] < 0) owner[key] = slot;
         OP_WAIT: if (waiting[slot] < 0) waiting[slot] = key;
         OP_DETECT: begin
            groups = find_groups();
            if (groups == 0) begin
               r = '{deadlock_index: 0, member_name: 0, deadlock_total: 0, last: 1};
               members_due.push_back(r);
            end else begin
               n = 0;
               for (int g = 1; g <= groups; g++)
                  for (int p = 0; p < NPROC; p++)
                     if (mark[p] == g && n < RES_CAP) begin
                        r.deadlock_index = g[4:0];
                        r.member_name = pname[p];
                        r.deadlock_total = groups[4:0];
                        r.last = 0;
                        members_due.push_back(r);
                        n++;
                     end
               members_due[members_due.size() - 1].last = 1;
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         wipe_tables();
         members_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{deadlock_index: rsp_tdata[4:0], member_name: rsp_tdata[20:5],
                    deadlock_total: rsp_tdata[25:21], last: rsp_tlast};
            if (members_due.size() == 0) begin
               $display("%0t: unexpected response, got %h", $time, got);
               errors++;
            end else begin
               want = members_due.pop_front();
               if (got.deadlock_index !== want.deadlock_index) begin
                  $display("%0t: deadlock_index expected %0d got %0d", $time,
                           want.deadlock_index, got.deadlock_index);
                  errors++;
               end
               if (got.member_name !== want.member_name) begin
                  $display("%0t: member_name expected %h got %h", $time,
                           want.member_name, got.member_name);
                  errors++;
               end
               if (got.deadlock_total !== want.deadlock_total) begin
                  $display("%0t: deadlock_total expected %0d got %0d", $time,
                           want.deadlock_total, got.deadlock_total);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b got %b", $time, want.last, got.last);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) apply_transfer(req_tdata);
      end
      pending <= members_due.size();
   end

endmodule

// ----- tb/wait_for_deadlock_detector_tb.sv -----
// ----------------------------------------------------------------------------
// wait_for_deadlock_detector_tb
// Drives the deadlock detector with load and detect transfers. A directed
// part comes first: table extremes, self waits, cycles, tails that run into a
// cycle, unlocked and orphan keys, repeated locks and requests, unknown
// opcodes and the group limit. After it come random well-formed scenarios,
// mixed with noise. The checker instance predicts and compares the results.
// ----------------------------------------------------------------------------
module wait_for_deadlock_detector_tb;
   import wfdd_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tready = 0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire         rsp_tlast;
   int          errors;
   int          pending;
   bit          gaps_on = 1;
   int          cycles = 0;
   int          sent = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   wait_for_deadlock_detector uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   wfdd_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .errors(errors), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : (!gaps_on || $urandom_range(99) >= 8);

   task automatic send(logic [2:0] op, logic [4:0] slot, logic [15:0] pid,
                       logic [5:0] key);
      if (gaps_on && $urandom_range(99) < 8) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b00, key, pid, slot, op};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random scenario: each member locks one key, then waits on one of those keys or, now and then, on a random key
   task automatic scenario();
      int n;
      logic [4:0] slots[$];
      logic [5:0] keys[$];
      n = $urandom_range(1, 8);
      send(OP_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < n; i++) begin
         slots.push_back($urandom);
         keys.push_back($urandom);
         send(OP_PROC, slots[i], $urandom, $urandom);
      end
      for (int i = 0; i < n; i++) send(OP_LOCK, slots[i], $urandom, keys[i]);
      for (int i = 0; i < n; i++)
         send(OP_WAIT, slots[i], $urandom,
              ($urandom_range(9) == 0) ? 6'($urandom) : keys[$urandom_range(n - 1)]);
      if ($urandom_range(3) == 0) send($urandom, $urandom, $urandom, $urandom);
      send(OP_DETECT, $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_PROC, 0, 16'h0000, 0);
      send(OP_PROC, 31, 16'hffff, 63);
      send(OP_DETECT, 0, 0, 0);
      send(OP_LOCK, 0, 0, 0);
      send(OP_WAIT, 0, 0, 0);
      send(OP_PROC, 3, 16'h0003, 0);
      send(OP_PROC, 4, 16'h0004, 0);
      send(OP_PROC, 1, 16'h0001, 0);
      send(OP_LOCK, 3, 0, 5);
      send(OP_LOCK, 4, 0, 6);
      send(OP_LOCK, 31, 0, 5);
      send(OP_LOCK, 1, 0, 7);
      send(OP_WAIT, 3, 0, 6);
      send(OP_WAIT, 4, 0, 5);
      send(OP_WAIT, 3, 0, 63);
      send(OP_WAIT, 1, 0, 6);
      send(OP_LOCK, 31, 0, 63);
      send(OP_WAIT, 31, 0, 62);
      send(OP_LOCK, 20, 0, 10);
      send(3'd5, 7, 16'h5555, 1);
      send(3'd6, 8, 16'haaaa, 2);
      send(3'd7, 9, 16'h1234, 3);
      send(OP_PROC, 3, 16'h1234, 0);
      send(OP_DETECT, 0, 0, 0);
      drain();
      send(OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < 32; i++) send(OP_PROC, 5'(i), $urandom, 0);
      for (int i = 0; i < 32; i++) send(OP_LOCK, 5'(i), 0, 6'(i));
      for (int i = 0; i < 32; i++) send(OP_WAIT, 5'(i), 0, 6'(i));
      send(OP_DETECT, 0, 0, 0);
      gaps_on = 0;
      repeat (3) scenario();
      gaps_on = 1;
      while (sent < 170) scenario();
      drain();
      repeat (300) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
